@@ rtl/c6502pd_pkg.sv @@
`default_nettype none

package c6502pd_pkg;

    localparam int ADDR_BITS = 16;

    localparam logic [5:0] M_UND = 6'd0;
    localparam logic [5:0] M_ADC = 6'd1;
    localparam logic [5:0] M_AND = 6'd2;
    localparam logic [5:0] M_ASL = 6'd3;
    localparam logic [5:0] M_BCC = 6'd4;
    localparam logic [5:0] M_BCS = 6'd5;
    localparam logic [5:0] M_BEQ = 6'd6;
    localparam logic [5:0] M_BIT = 6'd7;
    localparam logic [5:0] M_BMI = 6'd8;
    localparam logic [5:0] M_BNE = 6'd9;
    localparam logic [5:0] M_BPL = 6'd10;
    localparam logic [5:0] M_BRK = 6'd11;
    localparam logic [5:0] M_BVC = 6'd12;
    localparam logic [5:0] M_BVS = 6'd13;
    localparam logic [5:0] M_CLC = 6'd14;
    localparam logic [5:0] M_CLD = 6'd15;
    localparam logic [5:0] M_CLI = 6'd16;
    localparam logic [5:0] M_CLV = 6'd17;
    localparam logic [5:0] M_CMP = 6'd18;
    localparam logic [5:0] M_CPX = 6'd19;
    localparam logic [5:0] M_CPY = 6'd20;
    localparam logic [5:0] M_DEC = 6'd21;
    localparam logic [5:0] M_DEX = 6'd22;
    localparam logic [5:0] M_DEY = 6'd23;
    localparam logic [5:0] M_EOR = 6'd24;
    localparam logic [5:0] M_INC = 6'd25;
    localparam logic [5:0] M_INX = 6'd26;
    localparam logic [5:0] M_INY = 6'd27;
    localparam logic [5:0] M_JMP = 6'd28;
    localparam logic [5:0] M_JSR = 6'd29;
    localparam logic [5:0] M_LDA = 6'd30;
    localparam logic [5:0] M_LDX = 6'd31;
    localparam logic [5:0] M_LDY = 6'd32;
    localparam logic [5:0] M_LSR = 6'd33;
    localparam logic [5:0] M_NOP = 6'd34;
    localparam logic [5:0] M_ORA = 6'd35;
    localparam logic [5:0] M_PHA = 6'd36;
    localparam logic [5:0] M_PHP = 6'd37;
    localparam logic [5:0] M_PLA = 6'd38;
    localparam logic [5:0] M_PLP = 6'd39;
    localparam logic [5:0] M_ROL = 6'd40;
    localparam logic [5:0] M_ROR = 6'd41;
    localparam logic [5:0] M_RTI = 6'd42;
    localparam logic [5:0] M_RTS = 6'd43;
    localparam logic [5:0] M_SBC = 6'd44;
    localparam logic [5:0] M_SEC = 6'd45;
    localparam logic [5:0] M_SED = 6'd46;
    localparam logic [5:0] M_SEI = 6'd47;
    localparam logic [5:0] M_STA = 6'd48;
    localparam logic [5:0] M_STX = 6'd49;
    localparam logic [5:0] M_STY = 6'd50;
    localparam logic [5:0] M_TAX = 6'd51;
    localparam logic [5:0] M_TAY = 6'd52;
    localparam logic [5:0] M_TSX = 6'd53;
    localparam logic [5:0] M_TXA = 6'd54;
    localparam logic [5:0] M_TXS = 6'd55;
    localparam logic [5:0] M_TYA = 6'd56;

    localparam logic [3:0] A_ILL = 4'd0;
    localparam logic [3:0] A_IMP = 4'd1;
    localparam logic [3:0] A_ACC = 4'd2;
    localparam logic [3:0] A_IMM = 4'd3;
    localparam logic [3:0] A_ZP  = 4'd4;
    localparam logic [3:0] A_ZPX = 4'd5;
    localparam logic [3:0] A_ZPY = 4'd6;
    localparam logic [3:0] A_ABS = 4'd7;
    localparam logic [3:0] A_ABX = 4'd8;
    localparam logic [3:0] A_ABY = 4'd9;
    localparam logic [3:0] A_IND = 4'd10;
    localparam logic [3:0] A_XIN = 4'd11;
    localparam logic [3:0] A_INY = 4'd12;
    localparam logic [3:0] A_REL = 4'd13;

    typedef struct packed {
        logic [ADDR_BITS-1:0] instr_address;
        logic [7:0]           opcode;
        logic [7:0]           operand_low;
        logic [7:0]           operand_high;
    } item_t;

    typedef struct packed {
        logic [5:0]           mnemonic;
        logic [3:0]           addr_mode;
        logic [1:0]           length;
        logic                 valid_res;
        logic                 is_branch;
        logic [ADDR_BITS-1:0] branch_target;
        logic                 ends_flow;
    } result_t;

    typedef struct packed {
        logic [5:0] mnem;
        logic [3:0] mode;
    } op_entry_t;

    function automatic op_entry_t op_lookup(input logic [7:0] op);
        op_entry_t d;
        unique case (op)
            8'h00: d = {M_BRK, A_IMP};
            8'h01: d = {M_ORA, A_XIN};
            8'h05: d = {M_ORA, A_ZP};
            8'h06: d = {M_ASL, A_ZP};
            8'h08: d = {M_PHP, A_IMP};
            8'h09: d = {M_ORA, A_IMM};
            8'h0A: d = {M_ASL, A_ACC};
            8'h0D: d = {M_ORA, A_ABS};
            8'h0E: d = {M_ASL, A_ABS};
            8'h10: d = {M_BPL, A_REL};
            8'h11: d = {M_ORA, A_INY};
            8'h15: d = {M_ORA, A_ZPX};
            8'h16: d = {M_ASL, A_ZPX};
            8'h18: d = {M_CLC, A_IMP};
            8'h19: d = {M_ORA, A_ABY};
            8'h1D: d = {M_ORA, A_ABX};
            8'h1E: d = {M_ASL, A_ABX};
            8'h20: d = {M_JSR, A_ABS};
            8'h21: d = {M_AND, A_XIN};
            8'h24: d = {M_BIT, A_ZP};
            8'h25: d = {M_AND, A_ZP};
            8'h26: d = {M_ROL, A_ZP};
            8'h28: d = {M_PLP, A_IMP};
            8'h29: d = {M_AND, A_IMM};
            8'h2A: d = {M_ROL, A_ACC};
            8'h2C: d = {M_BIT, A_ABS};
            8'h2D: d = {M_AND, A_ABS};
            8'h2E: d = {M_ROL, A_ABS};
            8'h30: d = {M_BMI, A_REL};
            8'h31: d = {M_AND, A_INY};
            8'h35: d = {M_AND, A_ZPX};
            8'h36: d = {M_ROL, A_ZPX};
            8'h38: d = {M_SEC, A_IMP};
            8'h39: d = {M_AND, A_ABY};
            8'h3D: d = {M_AND, A_ABX};
            8'h3E: d = {M_ROL, A_ABX};
            8'h40: d = {M_RTI, A_IMP};
            8'h41: d = {M_EOR, A_XIN};
            8'h45: d = {M_EOR, A_ZP};
            8'h46: d = {M_LSR, A_ZP};
            8'h48: d = {M_PHA, A_IMP};
            8'h49: d = {M_EOR, A_IMM};
            8'h4A: d = {M_LSR, A_ACC};
            8'h4C: d = {M_JMP, A_ABS};
            8'h4D: d = {M_EOR, A_ABS};
            8'h4E: d = {M_LSR, A_ABS};
            8'h50: d = {M_BVC, A_REL};
            8'h51: d = {M_EOR, A_INY};
            8'h55: d = {M_EOR, A_ZPX};
            8'h56: d = {M_LSR, A_ZPX};
            8'h58: d = {M_CLI, A_IMP};
            8'h59: d = {M_EOR, A_ABY};
            8'h5D: d = {M_EOR, A_ABX};
            8'h5E: d = {M_LSR, A_ABX};
            8'h60: d = {M_RTS, A_IMP};
            8'h61: d = {M_ADC, A_XIN};
            8'h65: d = {M_ADC, A_ZP};
            8'h66: d = {M_ROR, A_ZP};
            8'h68: d = {M_PLA, A_IMP};
            8'h69: d = {M_ADC, A_IMM};
            8'h6A: d = {M_ROR, A_ACC};
            8'h6C: d = {M_JMP, A_IND};
            8'h6D: d = {M_ADC, A_ABS};
            8'h6E: d = {M_ROR, A_ABS};
            8'h70: d = {M_BVS, A_REL};
            8'h71: d = {M_ADC, A_INY};
            8'h75: d = {M_ADC, A_ZPX};
            8'h76: d = {M_ROR, A_ZPX};
            8'h78: d = {M_SEI, A_IMP};
            8'h79: d = {M_ADC, A_ABY};
            8'h7D: d = {M_ADC, A_ABX};
            8'h7E: d = {M_ROR, A_ABX};
            8'h81: d = {M_STA, A_XIN};
            8'h84: d = {M_STY, A_ZP};
            8'h85: d = {M_STA, A_ZP};
            8'h86: d = {M_STX, A_ZP};
            8'h88: d = {M_DEY, A_IMP};
            8'h8A: d = {M_TXA, A_IMP};
            8'h8C: d = {M_STY, A_ABS};
            8'h8D: d = {M_STA, A_ABS};
            8'h8E: d = {M_STX, A_ABS};
            8'h90: d = {M_BCC, A_REL};
            8'h91: d = {M_STA, A_INY};
            8'h94: d = {M_STY, A_ZPX};
            8'h95: d = {M_STA, A_ZPX};
            8'h96: d = {M_STX, A_ZPY};
            8'h98: d = {M_TYA, A_IMP};
            8'h99: d = {M_STA, A_ABY};
            8'h9A: d = {M_TXS, A_IMP};
            8'h9D: d = {M_STA, A_ABX};
            8'hA0: d = {M_LDY, A_IMM};
            8'hA1: d = {M_LDA, A_XIN};
            8'hA2: d = {M_LDX, A_IMM};
            8'hA4: d = {M_LDY, A_ZP};
            8'hA5: d = {M_LDA, A_ZP};
            8'hA6: d = {M_LDX, A_ZP};
            8'hA8: d = {M_TAY, A_IMP};
            8'hA9: d = {M_LDA, A_IMM};
            8'hAA: d = {M_TAX, A_IMP};
            8'hAC: d = {M_LDY, A_ABS};
            8'hAD: d = {M_LDA, A_ABS};
            8'hAE: d = {M_LDX, A_ABS};
            8'hB0: d = {M_BCS, A_REL};
            8'hB1: d = {M_LDA, A_INY};
            8'hB4: d = {M_LDY, A_ZPX};
            8'hB5: d = {M_LDA, A_ZPX};
            8'hB6: d = {M_LDX, A_ZPY};
            8'hB8: d = {M_CLV, A_IMP};
            8'hB9: d = {M_LDA, A_ABY};
            8'hBA: d = {M_TSX, A_IMP};
            8'hBC: d = {M_LDY, A_ABX};
            8'hBD: d = {M_LDA, A_ABX};
            8'hBE: d = {M_LDX, A_ABY};
            8'hC0: d = {M_CPY, A_IMM};
            8'hC1: d = {M_CMP, A_XIN};
            8'hC4: d = {M_CPY, A_ZP};
            8'hC5: d = {M_CMP, A_ZP};
            8'hC6: d = {M_DEC, A_ZP};
            8'hC8: d = {M_INY, A_IMP};
            8'hC9: d = {M_CMP, A_IMM};
            8'hCA: d = {M_DEX, A_IMP};
            8'hCC: d = {M_CPY, A_ABS};
            8'hCD: d = {M_CMP, A_ABS};
            8'hCE: d = {M_DEC, A_ABS};
            8'hD0: d = {M_BNE, A_REL};
            8'hD1: d = {M_CMP, A_INY};
            8'hD5: d = {M_CMP, A_ZPX};
            8'hD6: d = {M_DEC, A_ZPX};
            8'hD8: d = {M_CLD, A_IMP};
            8'hD9: d = {M_CMP, A_ABY};
            8'hDD: d = {M_CMP, A_ABX};
            8'hDE: d = {M_DEC, A_ABX};
            8'hE0: d = {M_CPX, A_IMM};
            8'hE1: d = {M_SBC, A_XIN};
            8'hE4: d = {M_CPX, A_ZP};
            8'hE5: d = {M_SBC, A_ZP};
            8'hE6: d = {M_INC, A_ZP};
            8'hE8: d = {M_INX, A_IMP};
            8'hE9: d = {M_SBC, A_IMM};
            8'hEA: d = {M_NOP, A_IMP};
            8'hEC: d = {M_CPX, A_ABS};
            8'hED: d = {M_SBC, A_ABS};
            8'hEE: d = {M_INC, A_ABS};
            8'hF0: d = {M_BEQ, A_REL};
            8'hF1: d = {M_SBC, A_INY};
            8'hF5: d = {M_SBC, A_ZPX};
            8'hF6: d = {M_INC, A_ZPX};
            8'hF8: d = {M_SED, A_IMP};
            8'hF9: d = {M_SBC, A_ABY};
            8'hFD: d = {M_SBC, A_ABX};
            8'hFE: d = {M_INC, A_ABX};
            default: d = {M_UND, A_ILL};
        endcase
        return d;
    endfunction

    function automatic logic [1:0] mode_length(input logic [3:0] mode);
        logic [1:0] len;
        unique case (mode)
            A_IMP, A_ACC: len = 2'd1;
            A_IMM, A_ZP, A_ZPX, A_ZPY, A_XIN, A_INY, A_REL: len = 2'd2;
            A_ABS, A_ABX, A_ABY, A_IND: len = 2'd3;
            default: len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cpu6502_instruction_predecode.sv @@
`default_nettype none

// Predecodes one 6502 instruction per beat: opcode byte, the two bytes after
// it and its address go in; mnemonic index, addressing mode, length, a valid
// flag, branch flag with computed target and an end-of-flow flag come out.
// An input beat is registered in in_reg, decoded through the opcode table and
// one 16-bit add, and the result is registered in res_reg; a new beat is taken
// every cycle while the result side does not stall. Undocumented opcodes give
// all-zero results.

module cpu6502_instruction_predecode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  c6502pd_pkg::item_t     item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output c6502pd_pkg::result_t   result
);
    import c6502pd_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_reg;
    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;
    result_t dec_res;
    logic    res_open;
    logic    item_take;

    assign res_open   = !res_valid_reg || !result_stall;
    assign item_stall = in_valid_reg && !res_open;
    assign item_take  = item_valid && !item_stall;

    assign in_valid_next  = item_take || (in_valid_reg && !res_open);
    assign res_valid_next = res_open ? in_valid_reg : 1'b1;

    c6502pd_decode u_decode (
        .item (in_reg),
        .res  (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_reg <= item;
        end
        if (res_open && in_valid_reg)
        begin
            res_reg <= dec_res;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_valid_reg && res_valid_reg && result_stall)
        else $error("input stalled without both stages full");

    a_decoded_beat_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && res_open |=> result_valid)
        else $error("decoded beat lost");

    a_illegal_all_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.valid_res |->
            result.length == 2'd0 && result.addr_mode == A_ILL
            && !result.is_branch && !result.ends_flow)
        else $error("undocumented opcode with nonzero decode");

    a_no_target_without_branch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.is_branch |-> result.branch_target == '0)
        else $error("target set on non-branch");

    a_flow_branch_is_jmp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.ends_flow && result.is_branch |->
            result.mnemonic == M_JMP && result.addr_mode == A_ABS)
        else $error("ending branch other than jmp absolute");
`endif

endmodule

`default_nettype wire

@@ rtl/c6502pd_decode.sv @@
`default_nettype none

module c6502pd_decode (
    input  c6502pd_pkg::item_t   item,
    output c6502pd_pkg::result_t res
);
    import c6502pd_pkg::*;

    op_entry_t            entry;
    logic [ADDR_BITS-1:0] rel_target;
    logic [ADDR_BITS-1:0] abs_target;
    logic                 is_rel;
    logic                 is_jmp_abs;
    logic                 is_jsr_abs;

    assign entry = op_lookup(item.opcode);

    // signed offset from the byte after the instruction, wraps at the top
    assign rel_target = item.instr_address + ADDR_BITS'(2)
                      + {{(ADDR_BITS-8){item.operand_low[7]}}, item.operand_low};
    assign abs_target = ADDR_BITS'({item.operand_high, item.operand_low});

    assign is_rel     = (entry.mode == A_REL);
    assign is_jmp_abs = (entry.mode == A_ABS) && (entry.mnem == M_JMP);
    assign is_jsr_abs = (entry.mode == A_ABS) && (entry.mnem == M_JSR);

    always_comb
    begin
        res.mnemonic  = entry.mnem;
        res.addr_mode = entry.mode;
        res.length    = mode_length(entry.mode);
        res.valid_res = (entry.mnem != M_UND);
        res.is_branch = is_rel || is_jmp_abs || is_jsr_abs;
        res.ends_flow = is_jmp_abs || (entry.mnem == M_RTS) || (entry.mnem == M_RTI);
        priority if (is_rel)
        begin
            res.branch_target = rel_target;
        end
        else if (is_jmp_abs || is_jsr_abs)
        begin
            res.branch_target = abs_target;
        end
        else
        begin
            res.branch_target = '0;
        end
    end

endmodule

`default_nettype wire

@@ tb/c6502pd_checker.sv @@
`timescale 1ns / 100ps

module c6502pd_checker
    import c6502pd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  item_t       item,
    input  logic        result_valid,
    input  logic        result_stall,
    input  result_t     result,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    result_t     expected_decodes[$];
    int unsigned fail_count = 0;
    int unsigned waiting = 0;

    assign mismatches  = fail_count;
    assign outstanding = waiting;

    function automatic result_t decode_instr(input item_t b);
        result_t     r;
        logic [15:0] offset;
        r = '0;
        if (b.opcode[1:0] == 2'b01)
        begin
            // regular accumulator group: operation in bits 7:5, mode in bits 4:2
            case (b.opcode[7:5])
                3'd0: r.mnemonic = M_ORA;
                3'd1: r.mnemonic = M_AND;
                3'd2: r.mnemonic = M_EOR;
                3'd3: r.mnemonic = M_ADC;
                3'd4: r.mnemonic = M_STA;
                3'd5: r.mnemonic = M_LDA;
                3'd6: r.mnemonic = M_CMP;
                default: r.mnemonic = M_SBC;
            endcase
            case (b.opcode[4:2])
                3'd0: r.addr_mode = A_XIN;
                3'd1: r.addr_mode = A_ZP;
                3'd2: r.addr_mode = A_IMM;
                3'd3: r.addr_mode = A_ABS;
                3'd4: r.addr_mode = A_INY;
                3'd5: r.addr_mode = A_ZPX;
                3'd6: r.addr_mode = A_ABY;
                default: r.addr_mode = A_ABX;
            endcase
            // no store immediate
            if (b.opcode == 8'h89)
            begin
                r.mnemonic  = M_UND;
                r.addr_mode = A_ILL;
            end
        end
        else
        begin
            case (b.opcode)
                8'h00: {r.mnemonic, r.addr_mode} = {M_BRK, A_IMP};
                8'h06: {r.mnemonic, r.addr_mode} = {M_ASL, A_ZP};
                8'h08: {r.mnemonic, r.addr_mode} = {M_PHP, A_IMP};
                8'h0A: {r.mnemonic, r.addr_mode} = {M_ASL, A_ACC};
                8'h0E: {r.mnemonic, r.addr_mode} = {M_ASL, A_ABS};
                8'h10: {r.mnemonic, r.addr_mode} = {M_BPL, A_REL};
                8'h16: {r.mnemonic, r.addr_mode} = {M_ASL, A_ZPX};
                8'h18: {r.mnemonic, r.addr_mode} = {M_CLC, A_IMP};
                8'h1E: {r.mnemonic, r.addr_mode} = {M_ASL, A_ABX};
                8'h20: {r.mnemonic, r.addr_mode} = {M_JSR, A_ABS};
                8'h24: {r.mnemonic, r.addr_mode} = {M_BIT, A_ZP};
                8'h26: {r.mnemonic, r.addr_mode} = {M_ROL, A_ZP};
                8'h28: {r.mnemonic, r.addr_mode} = {M_PLP, A_IMP};
                8'h2A: {r.mnemonic, r.addr_mode} = {M_ROL, A_ACC};
                8'h2C: {r.mnemonic, r.addr_mode} = {M_BIT, A_ABS};
                8'h2E: {r.mnemonic, r.addr_mode} = {M_ROL, A_ABS};
                8'h30: {r.mnemonic, r.addr_mode} = {M_BMI, A_REL};
                8'h36: {r.mnemonic, r.addr_mode} = {M_ROL, A_ZPX};
                8'h38: {r.mnemonic, r.addr_mode} = {M_SEC, A_IMP};
                8'h3E: {r.mnemonic, r.addr_mode} = {M_ROL, A_ABX};
                8'h40: {r.mnemonic, r.addr_mode} = {M_RTI, A_IMP};
                8'h46: {r.mnemonic, r.addr_mode} = {M_LSR, A_ZP};
                8'h48: {r.mnemonic, r.addr_mode} = {M_PHA, A_IMP};
                8'h4A: {r.mnemonic, r.addr_mode} = {M_LSR, A_ACC};
                8'h4C: {r.mnemonic, r.addr_mode} = {M_JMP, A_ABS};
                8'h4E: {r.mnemonic, r.addr_mode} = {M_LSR, A_ABS};
                8'h50: {r.mnemonic, r.addr_mode} = {M_BVC, A_REL};
                8'h56: {r.mnemonic, r.addr_mode} = {M_LSR, A_ZPX};
                8'h58: {r.mnemonic, r.addr_mode} = {M_CLI, A_IMP};
                8'h5E: {r.mnemonic, r.addr_mode} = {M_LSR, A_ABX};
                8'h60: {r.mnemonic, r.addr_mode} = {M_RTS, A_IMP};
                8'h66: {r.mnemonic, r.addr_mode} = {M_ROR, A_ZP};
                8'h68: {r.mnemonic, r.addr_mode} = {M_PLA, A_IMP};
                8'h6A: {r.mnemonic, r.addr_mode} = {M_ROR, A_ACC};
                8'h6C: {r.mnemonic, r.addr_mode} = {M_JMP, A_IND};
                8'h6E: {r.mnemonic, r.addr_mode} = {M_ROR, A_ABS};
                8'h70: {r.mnemonic, r.addr_mode} = {M_BVS, A_REL};
                8'h76: {r.mnemonic, r.addr_mode} = {M_ROR, A_ZPX};
                8'h78: {r.mnemonic, r.addr_mode} = {M_SEI, A_IMP};
                8'h7E: {r.mnemonic, r.addr_mode} = {M_ROR, A_ABX};
                8'h84: {r.mnemonic, r.addr_mode} = {M_STY, A_ZP};
                8'h86: {r.mnemonic, r.addr_mode} = {M_STX, A_ZP};
                8'h88: {r.mnemonic, r.addr_mode} = {M_DEY, A_IMP};
                8'h8A: {r.mnemonic, r.addr_mode} = {M_TXA, A_IMP};
                8'h8C: {r.mnemonic, r.addr_mode} = {M_STY, A_ABS};
                8'h8E: {r.mnemonic, r.addr_mode} = {M_STX, A_ABS};
                8'h90: {r.mnemonic, r.addr_mode} = {M_BCC, A_REL};
                8'h94: {r.mnemonic, r.addr_mode} = {M_STY, A_ZPX};
                8'h96: {r.mnemonic, r.addr_mode} = {M_STX, A_ZPY};
                8'h98: {r.mnemonic, r.addr_mode} = {M_TYA, A_IMP};
                8'h9A: {r.mnemonic, r.addr_mode} = {M_TXS, A_IMP};
                8'hA0: {r.mnemonic, r.addr_mode} = {M_LDY, A_IMM};
                8'hA2: {r.mnemonic, r.addr_mode} = {M_LDX, A_IMM};
                8'hA4: {r.mnemonic, r.addr_mode} = {M_LDY, A_ZP};
                8'hA6: {r.mnemonic, r.addr_mode} = {M_LDX, A_ZP};
                8'hA8: {r.mnemonic, r.addr_mode} = {M_TAY, A_IMP};
                8'hAA: {r.mnemonic, r.addr_mode} = {M_TAX, A_IMP};
                8'hAC: {r.mnemonic, r.addr_mode} = {M_LDY, A_ABS};
                8'hAE: {r.mnemonic, r.addr_mode} = {M_LDX, A_ABS};
                8'hB0: {r.mnemonic, r.addr_mode} = {M_BCS, A_REL};
                8'hB4: {r.mnemonic, r.addr_mode} = {M_LDY, A_ZPX};
                8'hB6: {r.mnemonic, r.addr_mode} = {M_LDX, A_ZPY};
                8'hB8: {r.mnemonic, r.addr_mode} = {M_CLV, A_IMP};
                8'hBA: {r.mnemonic, r.addr_mode} = {M_TSX, A_IMP};
                8'hBC: {r.mnemonic, r.addr_mode} = {M_LDY, A_ABX};
                8'hBE: {r.mnemonic, r.addr_mode} = {M_LDX, A_ABY};
                8'hC0: {r.mnemonic, r.addr_mode} = {M_CPY, A_IMM};
                8'hC4: {r.mnemonic, r.addr_mode} = {M_CPY, A_ZP};
                8'hC6: {r.mnemonic, r.addr_mode} = {M_DEC, A_ZP};
                8'hC8: {r.mnemonic, r.addr_mode} = {M_INY, A_IMP};
                8'hCA: {r.mnemonic, r.addr_mode} = {M_DEX, A_IMP};
                8'hCC: {r.mnemonic, r.addr_mode} = {M_CPY, A_ABS};
                8'hCE: {r.mnemonic, r.addr_mode} = {M_DEC, A_ABS};
                8'hD0: {r.mnemonic, r.addr_mode} = {M_BNE, A_REL};
                8'hD6: {r.mnemonic, r.addr_mode} = {M_DEC, A_ZPX};
                8'hD8: {r.mnemonic, r.addr_mode} = {M_CLD, A_IMP};
                8'hDE: {r.mnemonic, r.addr_mode} = {M_DEC, A_ABX};
                8'hE0: {r.mnemonic, r.addr_mode} = {M_CPX, A_IMM};
                8'hE4: {r.mnemonic, r.addr_mode} = {M_CPX, A_ZP};
                8'hE6: {r.mnemonic, r.addr_mode} = {M_INC, A_ZP};
                8'hE8: {r.mnemonic, r.addr_mode} = {M_INX, A_IMP};
                8'hEA: {r.mnemonic, r.addr_mode} = {M_NOP, A_IMP};
                8'hEC: {r.mnemonic, r.addr_mode} = {M_CPX, A_ABS};
                8'hEE: {r.mnemonic, r.addr_mode} = {M_INC, A_ABS};
                8'hF0: {r.mnemonic, r.addr_mode} = {M_BEQ, A_REL};
                8'hF6: {r.mnemonic, r.addr_mode} = {M_INC, A_ZPX};
                8'hF8: {r.mnemonic, r.addr_mode} = {M_SED, A_IMP};
                8'hFE: {r.mnemonic, r.addr_mode} = {M_INC, A_ABX};
                default: {r.mnemonic, r.addr_mode} = {M_UND, A_ILL};
            endcase
        end

        case (r.addr_mode)
            A_IMP, A_ACC: r.length = 2'd1;
            A_ABS, A_ABX, A_ABY, A_IND: r.length = 2'd3;
            A_ILL: r.length = 2'd0;
            default: r.length = 2'd2;
        endcase
        r.valid_res = (r.mnemonic != M_UND);

        if (r.addr_mode == A_REL)
        begin
            offset          = {{8{b.operand_low[7]}}, b.operand_low};
            r.is_branch     = 1'b1;
            r.branch_target = b.instr_address + 16'd2 + offset;
        end
        else if (r.addr_mode == A_ABS && (r.mnemonic == M_JSR || r.mnemonic == M_JMP))
        begin
            r.is_branch     = 1'b1;
            r.branch_target = {b.operand_high, b.operand_low};
        end
        r.ends_flow = (r.addr_mode == A_ABS && r.mnemonic == M_JMP)
                      || r.mnemonic == M_RTS || r.mnemonic == M_RTI;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            expected_decodes.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_decodes.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat expected none got %p", $time, result);
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    check_field("mnemonic", 16'(want.mnemonic), 16'(result.mnemonic));
                    check_field("addr_mode", 16'(want.addr_mode), 16'(result.addr_mode));
                    check_field("length", 16'(want.length), 16'(result.length));
                    check_field("valid_res", 16'(want.valid_res), 16'(result.valid_res));
                    check_field("is_branch", 16'(want.is_branch), 16'(result.is_branch));
                    check_field("branch_target", want.branch_target, result.branch_target);
                    check_field("ends_flow", 16'(want.ends_flow), 16'(result.ends_flow));
                end
            end
            if (item_valid && !item_stall)
                expected_decodes.push_back(decode_instr(item));
        end
        waiting = expected_decodes.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import c6502pd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned PHASE_BEATS = 275;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    cpu6502_instruction_predecode uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    c6502pd_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic item_t make_instr(input logic [15:0] addr, input logic [7:0] op,
                                         input logic [7:0] lo, input logic [7:0] hi);
        item_t b;
        b.instr_address = addr;
        b.opcode        = op;
        b.operand_low   = lo;
        b.operand_high  = hi;
        return b;
    endfunction

    task automatic send_instr(input item_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= b;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic send_random_instr();
        logic [15:0] addr;
        // lean on both ends of memory so branch targets wrap
        case ($urandom_range(7))
            0: addr = 16'($urandom_range(16'hFFFF, 16'hFF00));
            1: addr = 16'($urandom_range(16'h00FF, 16'h0000));
            default: addr = 16'($urandom_range(16'hFFFF, 16'h0000));
        endcase
        send_instr(make_instr(addr, 8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255))));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_instr(make_instr(16'h0000, 8'h00, 8'h00, 8'h00));
        send_instr(make_instr(16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        send_instr(make_instr(16'h1234, 8'h11, 8'h55, 8'hAA));
        send_instr(make_instr(16'hC000, 8'h20, 8'h34, 8'h12));
        send_instr(make_instr(16'hFFFD, 8'h4C, 8'hFF, 8'hFF));
        send_instr(make_instr(16'h8000, 8'h6C, 8'h00, 8'h02));
        send_instr(make_instr(16'h0200, 8'h60, 8'hFF, 8'h00));
        send_instr(make_instr(16'h0300, 8'h40, 8'h00, 8'hFF));
        send_instr(make_instr(16'hFFFE, 8'h10, 8'h7F, 8'h00));
        send_instr(make_instr(16'h0000, 8'h30, 8'h80, 8'h00));
        send_instr(make_instr(16'h0100, 8'hD0, 8'hFE, 8'h00));
        send_instr(make_instr(16'hFFFD, 8'hF0, 8'h01, 8'hFF));
        send_instr(make_instr(16'h4000, 8'h89, 8'h12, 8'h34));
        send_instr(make_instr(16'h4001, 8'h02, 8'h00, 8'h00));
        send_instr(make_instr(16'h4002, 8'h9E, 8'hFF, 8'hFF));
        send_instr(make_instr(16'h4003, 8'h0A, 8'h00, 8'h00));
        send_instr(make_instr(16'h4004, 8'hA2, 8'h80, 8'h00));
        send_instr(make_instr(16'h4005, 8'h96, 8'h10, 8'h00));
        send_instr(make_instr(16'h4006, 8'hBE, 8'h00, 8'h80));
        send_instr(make_instr(16'h4007, 8'hEA, 8'h00, 8'h00));
        send_instr(make_instr(16'h4008, 8'h9A, 8'h00, 8'h00));
        send_instr(make_instr(16'h4009, 8'h81, 8'h44, 8'h00));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 74; end
                default: begin send_idle_pct = 28; recv_stall_pct <= 28; end
            endcase
            repeat (PHASE_BEATS) send_random_instr();
        end
        item_valid <= 1'b0;
        @(posedge clk);

        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
